FILE: rtl/bse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_pkg
// shared types, constants, microcode encoding and the per-cell voltage curve
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int WINDOW_DEPTH_DEF = 8;

    localparam int MV_W       = 16;
    localparam int PWR_W      = 16;
    localparam int CELLS_W    = 5;
    localparam int AH_W       = 10;
    localparam int LIMIT_W    = 15;
    localparam int SOC_W      = 7;
    localparam int CAP_W      = 20;
    localparam int PROD_W     = AH_W + SOC_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int DIVR_W     = 7;
    localparam int PC_W       = 5;
    localparam int SEG_W      = 4;
    localparam int SCALED_W   = 11;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(300);
    localparam logic [SOC_W-1:0]   SOC_MAX     = SOC_W'(100);
    localparam logic [SOC_W-1:0]   SOC_STEP    = SOC_W'(10);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SERIES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PACK_AH     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_LIMIT = CFG_IDX_W'(2);

    // per-cell open-circuit curve, 10 percent apart
    localparam logic [MV_W-1:0] CURVE_MV [11] = '{
        16'd3270, 16'd3390, 16'd3510, 16'd3610, 16'd3680, 16'd3740,
        16'd3820, 16'd3930, 16'd4050, 16'd4130, 16'd4200
    };

    typedef struct packed {
        logic [MV_W-1:0]         pack_millivolts;
        logic signed [PWR_W-1:0] power_watts;
    } t_in_word;

    typedef struct packed {
        logic             soc_updated;
        logic             capacity_updated;
        logic [SOC_W-1:0] soc_percent;
        logic [CAP_W-1:0] capacity_left_mah;
    } t_out_word;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIV_MV,
        OP_DIV_SUM,
        OP_DIV_AVG,
        OP_LOOKUP,
        OP_SOC_SET,
        OP_STORE,
        OP_MUL,
        OP_CAP,
        OP_DROP,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_NOT_OK,
        COND_NOT_EMPTY,
        COND_NOT_STORE,
        COND_NOT_FULL,
        COND_CLAMPED,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ucode;

    typedef struct packed {
        logic run;
        t_op  op;
    } t_ctrl;

    typedef struct packed {
        logic ok;
        logic empty;
        logic store;
        logic full;
        logic clamped;
        logic div_busy;
        logic out_busy;
    } t_status;

    typedef struct packed {
        logic                clamped;
        logic [SOC_W-1:0]    soc_clamp;
        logic [SOC_W-1:0]    base;
        logic [SCALED_W-1:0] scaled;
        logic [DIVR_W-1:0]   span;
    } t_lookup;

    // program steps
    localparam logic [PC_W-1:0] STEP_CHECK         = PC_W'(0);
    localparam logic [PC_W-1:0] STEP_EMPTY         = PC_W'(1);
    localparam logic [PC_W-1:0] STEP_DIV_MV        = PC_W'(2);
    localparam logic [PC_W-1:0] STEP_WAIT_MV       = PC_W'(3);
    localparam logic [PC_W-1:0] STEP_LOOKUP_MV     = PC_W'(4);
    localparam logic [PC_W-1:0] STEP_WAIT_SPAN_MV  = PC_W'(5);
    localparam logic [PC_W-1:0] STEP_SOC_MV        = PC_W'(6);
    localparam logic [PC_W-1:0] STEP_GATE          = PC_W'(7);
    localparam logic [PC_W-1:0] STEP_STORE         = PC_W'(8);
    localparam logic [PC_W-1:0] STEP_DIV_SUM       = PC_W'(9);
    localparam logic [PC_W-1:0] STEP_WAIT_SUM      = PC_W'(10);
    localparam logic [PC_W-1:0] STEP_DIV_AVG       = PC_W'(11);
    localparam logic [PC_W-1:0] STEP_WAIT_AVG      = PC_W'(12);
    localparam logic [PC_W-1:0] STEP_LOOKUP_AVG    = PC_W'(13);
    localparam logic [PC_W-1:0] STEP_WAIT_SPAN_AVG = PC_W'(14);
    localparam logic [PC_W-1:0] STEP_SOC_AVG       = PC_W'(15);
    localparam logic [PC_W-1:0] STEP_MUL           = PC_W'(16);
    localparam logic [PC_W-1:0] STEP_CAP           = PC_W'(17);
    localparam logic [PC_W-1:0] STEP_DROP          = PC_W'(18);
    localparam logic [PC_W-1:0] STEP_EMIT          = PC_W'(19);

    // find the curve segment; interpolation numerator and span go to the divider
    function automatic t_lookup curve_lookup(input logic [MV_W-1:0] x);
        t_lookup          res;
        logic [SEG_W-1:0] seg;
        logic [MV_W-1:0]  lo;
        logic [MV_W-1:0]  diff;
        logic [MV_W-1:0]  span;
        res = '0;
        seg = SEG_W'(1);
        for (int i = 10; i >= 1; i--) begin
            if (x < CURVE_MV[i]) begin
                seg = SEG_W'(i);
            end
        end
        lo   = CURVE_MV[SEG_W'(seg - SEG_W'(1))];
        span = CURVE_MV[seg] - lo;
        diff = x - lo;
        if (x <= CURVE_MV[0]) begin
            res.clamped   = 1'b1;
            res.soc_clamp = '0;
        end else if (x >= CURVE_MV[10]) begin
            res.clamped   = 1'b1;
            res.soc_clamp = SOC_MAX;
        end
        res.base   = SOC_W'(SOC_W'(seg - SEG_W'(1)) * SOC_STEP);
        res.scaled = SCALED_W'(SCALED_W'(diff[DIVR_W-1:0]) * SCALED_W'(10));
        res.span   = span[DIVR_W-1:0];
        return res;
    endfunction

endpackage

FILE: rtl/bse_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bse_divider #(
    parameter int DVD_W = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DVD_W-1:0]           i_dividend,
    input  logic [bse_pkg::DIVR_W-1:0] i_divisor,
    output logic                       o_busy,
    output logic [DVD_W-1:0]           o_quotient
);
    import bse_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVD_W-1:0]  r_quo;
    logic [DIVR_W-1:0] r_rem;
    logic [DIVR_W-1:0] r_dvs;
    logic [DIVR_W:0]   trial;
    logic [DIVR_W:0]   diff;
    logic              fits;

    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/bse_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_sequencer
// step counter and microcode rom with conditional jumps
// ----------------------------------------------------------------------------
module bse_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  bse_pkg::t_status i_status,
    output bse_pkg::t_ctrl   o_ctrl
);
    import bse_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic            r_run;
    logic            n_run;
    t_ucode          word;
    logic            take;
    logic            hold;
    logic            op_en;

    // microcode program
    always_comb begin
        unique case (r_pc)
            STEP_CHECK:         word = '{OP_NOP,     COND_NOT_OK,    STEP_EMIT};
            STEP_EMPTY:         word = '{OP_NOP,     COND_NOT_EMPTY, STEP_GATE};
            STEP_DIV_MV:        word = '{OP_DIV_MV,  COND_NEXT,      STEP_CHECK};
            STEP_WAIT_MV:       word = '{OP_NOP,     COND_DIV_BUSY,  STEP_WAIT_MV};
            STEP_LOOKUP_MV:     word = '{OP_LOOKUP,  COND_CLAMPED,   STEP_GATE};
            STEP_WAIT_SPAN_MV:  word = '{OP_NOP,     COND_DIV_BUSY,  STEP_WAIT_SPAN_MV};
            STEP_SOC_MV:        word = '{OP_SOC_SET, COND_NEXT,      STEP_CHECK};
            STEP_GATE:          word = '{OP_NOP,     COND_NOT_STORE, STEP_EMIT};
            STEP_STORE:         word = '{OP_STORE,   COND_NOT_FULL,  STEP_EMIT};
            STEP_DIV_SUM:       word = '{OP_DIV_SUM, COND_NEXT,      STEP_CHECK};
            STEP_WAIT_SUM:      word = '{OP_NOP,     COND_DIV_BUSY,  STEP_WAIT_SUM};
            STEP_DIV_AVG:       word = '{OP_DIV_AVG, COND_NEXT,      STEP_CHECK};
            STEP_WAIT_AVG:      word = '{OP_NOP,     COND_DIV_BUSY,  STEP_WAIT_AVG};
            STEP_LOOKUP_AVG:    word = '{OP_LOOKUP,  COND_CLAMPED,   STEP_MUL};
            STEP_WAIT_SPAN_AVG: word = '{OP_NOP,     COND_DIV_BUSY,  STEP_WAIT_SPAN_AVG};
            STEP_SOC_AVG:       word = '{OP_SOC_SET, COND_NEXT,      STEP_CHECK};
            STEP_MUL:           word = '{OP_MUL,     COND_NEXT,      STEP_CHECK};
            STEP_CAP:           word = '{OP_CAP,     COND_NEXT,      STEP_CHECK};
            STEP_DROP:          word = '{OP_DROP,    COND_NEXT,      STEP_CHECK};
            STEP_EMIT:          word = '{OP_EMIT,    COND_OUT_BUSY,  STEP_EMIT};
            default:            word = '{OP_NOP,     COND_NOT_OK,    STEP_EMIT};
        endcase
    end

    always_comb begin
        unique case (word.cond)
            COND_NEXT:      take = 1'b0;
            COND_NOT_OK:    take = !i_status.ok;
            COND_NOT_EMPTY: take = !i_status.empty;
            COND_NOT_STORE: take = !i_status.store;
            COND_NOT_FULL:  take = !i_status.full;
            COND_CLAMPED:   take = i_status.clamped;
            COND_DIV_BUSY:  take = i_status.div_busy;
            COND_OUT_BUSY:  take = i_status.out_busy;
            default:        take = 1'b0;
        endcase
    end

    // a jump to the own step is a wait; its operation fires only on leaving
    always_comb begin
        hold  = take && (word.target == r_pc);
        op_en = r_run && !hold;
    end

    always_comb begin
        n_pc  = r_pc;
        n_run = r_run;
        if (!r_run) begin
            n_run = i_start;
        end else if (op_en && (word.op == OP_EMIT)) begin
            n_pc  = STEP_CHECK;
            n_run = 1'b0;
        end else if (take) begin
            n_pc = word.target;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= STEP_CHECK;
            r_run <= 1'b0;
        end else begin
            r_pc  <= n_pc;
            r_run <= n_run;
        end
    end

    always_comb begin
        o_ctrl.run = r_run;
        o_ctrl.op  = op_en ? word.op : OP_NOP;
    end

endmodule

FILE: rtl/battery_soc_estimator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_soc_estimator_unit
// voltage-based state of charge with a sliding sample window
// ----------------------------------------------------------------------------
// one word at a time: a pack-voltage sample and the power draw go in, one
// result word comes out per sample. a zero sample or a zero cell count gives
// an all-zero result. with an empty window the soc is set at once from the
// sample; samples taken above the power limit are not windowed. once the
// window holds WINDOW_DEPTH samples the mean per cell is interpolated on an
// 11-point curve and soc plus remaining mah are reported, then the oldest
// sample is dropped. the work runs from a 20-step microcode program. the
// window mean comes from a reciprocal multiply in one step; the division by
// the cell count and the curve interpolation share a restoring divider with
// N = 16 + clog2(WINDOW_DEPTH) quotient bits, one bit per cycle, and the
// program waits while it is busy. with a depth of 1 the first sample also
// fills the window. a clamped curve point skips one division. a stalled
// output register holds the program at its last step until the previous
// result is taken. a new word can be taken in the same cycle that the result
// first sits in the output register.
// ----------------------------------------------------------------------------
module battery_soc_estimator_unit #(
    parameter int WINDOW_DEPTH = bse_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bse_pkg::t_in_word              i_in_word,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bse_pkg::t_out_word             o_out_word,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bse_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bse_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bse_pkg::*;

    localparam int SUM_W  = MV_W + $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SLOT_W = CNT_W + 1;

    // window mean as sum * ceil(2^sh / depth) >> sh, exact for any sum
    localparam int RECIP_SH   = SUM_W + $clog2(WINDOW_DEPTH);
    localparam int RECIP_W    = SUM_W + 1;
    localparam int AVG_PROD_W = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(
        ((64'd1 << RECIP_SH) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

    // configuration registers
    logic [CELLS_W-1:0] r_cells;
    logic [AH_W-1:0]    r_ah;
    logic [LIMIT_W-1:0] r_limit;

    // latched sample
    logic [MV_W-1:0]         r_mv;
    logic signed [PWR_W-1:0] r_pw;

    // window bookkeeping
    logic [MV_W-1:0]  mem [WINDOW_DEPTH];
    logic [MV_W-1:0]  r_rdata;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_oldest;
    logic [SUM_W-1:0] r_sum;
    logic [SLOT_W-1:0] slot_raw;
    logic [IDX_W-1:0] slot;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [SUM_W-1:0]      r_avg;

    // result working registers
    logic              r_soc_upd;
    logic              r_cap_upd;
    logic [SOC_W-1:0]  r_soc;
    logic [SOC_W-1:0]  r_base;
    logic [PROD_W-1:0] r_prod;
    logic [CAP_W-1:0]  r_cap;

    // output register
    logic      r_out_valid;
    t_out_word r_out;

    // control
    t_ctrl            ctrl;
    t_status          status;
    t_lookup          lk;
    logic             accept;
    logic             div_start;
    logic             div_busy;
    logic [SUM_W-1:0] div_dividend;
    logic [DIVR_W-1:0] div_divisor;
    logic [SUM_W-1:0] quotient;

    assign accept      = i_in_valid && !ctrl.run;
    assign o_in_stall  = ctrl.run;
    assign o_cfg_ready = 1'b1;

    // register file, to be written only while idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= '0;
            r_ah    <= '0;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CELL_SERIES: r_cells <= i_cfg_data[CELLS_W-1:0];
                CFG_PACK_AH:     r_ah    <= i_cfg_data[AH_W-1:0];
                CFG_POWER_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // curve segment of the last quotient, mv per cell
    assign lk = curve_lookup(quotient[MV_W-1:0]);

    // window sum times the depth reciprocal
    assign avg_prod = AVG_PROD_W'(r_sum) * AVG_PROD_W'(RECIP_M);

    // next free slot, oldest plus count wrapped once
    always_comb begin
        slot_raw = SLOT_W'(r_oldest) + SLOT_W'(r_count);
        if (slot_raw >= SLOT_W'(WINDOW_DEPTH)) begin
            slot_raw = slot_raw - SLOT_W'(WINDOW_DEPTH);
        end
        slot = slot_raw[IDX_W-1:0];
    end

    // status flags for the jump conditions
    always_comb begin
        status.ok       = (r_mv != '0) && (r_cells != '0);
        status.empty    = (r_count == '0);
        status.store    = r_pw <= $signed({1'b0, r_limit});
        status.full     = (r_count == CNT_W'(WINDOW_DEPTH - 1));
        status.clamped  = lk.clamped;
        status.div_busy = div_busy;
        status.out_busy = r_out_valid && i_out_stall;
    end

    // divider operand select
    always_comb begin
        div_start    = 1'b0;
        div_dividend = SUM_W'(r_mv);
        div_divisor  = DIVR_W'(r_cells);
        unique case (ctrl.op)
            OP_DIV_MV: begin
                div_start = 1'b1;
            end
            OP_DIV_AVG: begin
                div_start    = 1'b1;
                div_dividend = r_avg;
            end
            OP_LOOKUP: begin
                // interpolation (x - lo) * 10 / span
                div_start    = !lk.clamped;
                div_dividend = SUM_W'(lk.scaled);
                div_divisor  = lk.span;
            end
            default: ;
        endcase
    end

    bse_divider #(
        .DVD_W(SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    bse_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    // sample window memory, oldest entry read every cycle
    always_ff @(posedge i_clk) begin
        if (ctrl.op == OP_STORE) begin
            mem[slot] <= r_mv;
        end
        r_rdata <= mem[r_oldest];
    end

    // window control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_oldest <= '0;
            r_sum    <= '0;
        end else begin
            unique case (ctrl.op)
                OP_STORE: begin
                    r_sum   <= r_sum + SUM_W'(r_mv);
                    r_count <= r_count + CNT_W'(1);
                end
                OP_DROP: begin
                    r_sum   <= r_sum - SUM_W'(r_rdata);
                    r_count <= r_count - CNT_W'(1);
                    if (r_oldest == IDX_W'(WINDOW_DEPTH - 1)) begin
                        r_oldest <= '0;
                    end else begin
                        r_oldest <= r_oldest + IDX_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // result datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mv      <= i_in_word.pack_millivolts;
            r_pw      <= i_in_word.power_watts;
            r_soc_upd <= 1'b0;
            r_cap_upd <= 1'b0;
            r_soc     <= '0;
            r_cap     <= '0;
        end else begin
            unique case (ctrl.op)
                OP_DIV_SUM: begin
                    // floor of the window mean
                    r_avg <= avg_prod[RECIP_SH +: SUM_W];
                end
                OP_LOOKUP: begin
                    r_base <= lk.base;
                    if (lk.clamped) begin
                        r_soc     <= lk.soc_clamp;
                        r_soc_upd <= 1'b1;
                    end
                end
                OP_SOC_SET: begin
                    r_soc     <= r_base + quotient[SOC_W-1:0];
                    r_soc_upd <= 1'b1;
                end
                OP_MUL: begin
                    r_prod <= PROD_W'(r_ah) * PROD_W'(r_soc);
                end
                OP_CAP: begin
                    // ah * 1000 * soc / 100 is exactly ah * soc * 10
                    r_cap     <= CAP_W'({r_prod, 3'b000}) + CAP_W'({r_prod, 1'b0});
                    r_cap_upd <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // output register frees the sequencer as soon as the result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.op == OP_EMIT) begin
            r_out.soc_updated       <= r_soc_upd;
            r_out.capacity_updated  <= r_cap_upd;
            r_out.soc_percent       <= r_soc;
            r_out.capacity_left_mah <= r_cap;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

FILE: tb/sv/battery_soc_estimator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_soc_estimator_unit_tb
// self-checking bench for the windowed state-of-charge estimator
// ----------------------------------------------------------------------------
// a queue-fed driver pushes voltage/power words into the block and a monitor
// compares every result word against an in-bench estimator that tracks the
// sample window and the register settings. the run steps through several
// register settings, extremes included, with random idling on both sides.
// ----------------------------------------------------------------------------
module battery_soc_estimator_unit_tb;
    import bse_pkg::*;

    localparam int WIN_DEPTH   = 8;
    localparam int CYCLE_LIMIT = 400000;
    // index past the end of the register list, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    // per-cell curve, 10 percent apart
    localparam int unsigned curve_pts_mv [11] = '{
        3270, 3390, 3510, 3610, 3680, 3740, 3820, 3930, 4050, 4130, 4200
    };

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_word              i_in_word   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // register shadow
    int unsigned cfg_cells;
    int unsigned cfg_amp_hours;
    int unsigned cfg_power_limit;

    // sample window shadow
    int unsigned win_mv [WIN_DEPTH];
    int unsigned win_count;
    int unsigned win_head;
    int unsigned win_sum;

    t_in_word  sample_q     [$];
    t_out_word soc_expect_q [$];

    int  error_cnt;
    int  sent_cnt;
    int  checked_cnt;
    int  window_upd_cnt;
    int  first_soc_cnt;
    int  setting_cnt;
    int  cycle_cnt;
    // no idling on either side while set
    bit  calm;

    battery_soc_estimator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // estimator
    // ------------------------------------------------------------------------

    // pack voltage -> percent, integer interpolation between curve points
    function automatic int unsigned pack_mv_to_soc(input int unsigned pack_mv);
        int unsigned per_cell;
        int unsigned lo;
        per_cell = pack_mv / cfg_cells;
        if (per_cell <= curve_pts_mv[0]) begin
            return 0;
        end
        if (per_cell >= curve_pts_mv[10]) begin
            return 100;
        end
        for (int i = 1; i < 11; i++) begin
            if (per_cell < curve_pts_mv[i]) begin
                lo = curve_pts_mv[i-1];
                return (i - 1) * 10 + ((per_cell - lo) * 10) / (curve_pts_mv[i] - lo);
            end
        end
        return 100;
    endfunction

    // one sample in, one result word out; updates the window shadow
    function automatic t_out_word estimate_soc(input t_in_word w);
        t_out_word   res;
        int          pwr;
        int unsigned mv;
        int unsigned slot;
        int unsigned soc;
        res = '0;
        mv  = 32'(w.pack_millivolts);
        pwr = 32'(w.power_watts);
        // no reading or unconfigured pack: nothing moves
        if (mv != 0 && cfg_cells != 0) begin
            // empty window: take the sample as-is for a quick estimate
            if (win_count == 0) begin
                res.soc_percent = SOC_W'(pack_mv_to_soc(mv));
                res.soc_updated = 1'b1;
                first_soc_cnt++;
            end
            // negative draw is always under the limit
            if (pwr <= int'(cfg_power_limit)) begin
                slot         = (win_head + win_count) % WIN_DEPTH;
                win_mv[slot] = mv;
                win_sum     += mv;
                win_count++;
                if (win_count >= WIN_DEPTH) begin
                    soc                   = pack_mv_to_soc(win_sum / WIN_DEPTH);
                    res.soc_percent       = SOC_W'(soc);
                    res.capacity_left_mah = CAP_W'(cfg_amp_hours * 1000 * soc / 100);
                    res.soc_updated       = 1'b1;
                    res.capacity_updated  = 1'b1;
                    win_sum  -= win_mv[win_head];
                    win_head  = (win_head + 1) % WIN_DEPTH;
                    win_count--;
                    window_upd_cnt++;
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // driver: sample words from the pending queue
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            soc_expect_q = {soc_expect_q, estimate_soc(i_in_word)};
            sent_cnt++;
        end
        // a stalled word holds, otherwise present the next one or idle
        if (!i_in_valid || !o_in_stall) begin
            if (i_rst_n && sample_q.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
                i_in_valid <= 1'b1;
                i_in_word  <= sample_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: result words against the oldest expectation
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [CAP_W-1:0] exp_v,
                               input logic [CAP_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            error_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (soc_expect_q.size() == 0) begin
                $display("%0t: result word with nothing expected, actual %h",
                         $time, o_out_word);
                error_cnt++;
            end else begin
                exp_w = soc_expect_q.pop_front();
                check_field("soc_updated", CAP_W'(exp_w.soc_updated),
                            CAP_W'(o_out_word.soc_updated));
                check_field("capacity_updated", CAP_W'(exp_w.capacity_updated),
                            CAP_W'(o_out_word.capacity_updated));
                check_field("soc_percent", CAP_W'(exp_w.soc_percent),
                            CAP_W'(o_out_word.soc_percent));
                check_field("capacity_left_mah", exp_w.capacity_left_mah,
                            o_out_word.capacity_left_mah);
                checked_cnt++;
            end
        end
        i_out_stall <= !calm && ($urandom_range(99) < 15);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, soc_expect_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------------

    // wait until the block has nothing in flight
    task automatic settle();
        while (sample_q.size() != 0 || i_in_valid || soc_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // leaves valid high so back-to-back writes never toggle it in one step
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            CFG_CELL_SERIES: cfg_cells       = 32'(data[CELLS_W-1:0]);
            CFG_PACK_AH:     cfg_amp_hours   = 32'(data[AH_W-1:0]);
            CFG_POWER_LIMIT: cfg_power_limit = 32'(data[LIMIT_W-1:0]);
            default: ;
        endcase
    endtask

    // upper data bits are random so the register masking gets exercised
    task automatic configure(input int unsigned cells, input int unsigned ah,
                             input int unsigned limit);
        settle();
        cfg_write(CFG_CELL_SERIES, {(CFG_DATA_W-CELLS_W)'($urandom), CELLS_W'(cells)});
        cfg_write(CFG_PACK_AH, {(CFG_DATA_W-AH_W)'($urandom), AH_W'(ah)});
        cfg_write(CFG_POWER_LIMIT, CFG_DATA_W'(limit));
        i_cfg_valid <= 1'b0;
        setting_cnt++;
    endtask

    // mostly plausible pack voltages and draws near the limit, some noise
    function automatic t_in_word random_sample();
        t_in_word    w;
        int unsigned pick;
        int unsigned mv;
        int          pwr;
        pick = $urandom_range(99);
        if (pick < 6) begin
            mv = 0;
        end else if (pick < 20) begin
            mv = $urandom_range(65535);
        end else begin
            mv = (cfg_cells == 0 ? 1 : cfg_cells) * $urandom_range(4350, 3150);
            if (mv > 65535) begin
                mv = 65535;
            end
        end
        pick = $urandom_range(99);
        if (pick < 72) begin
            pwr = int'($urandom_range(cfg_power_limit + 1500)) - 1500;
        end else if (pick < 86) begin
            pwr = int'(cfg_power_limit) + int'($urandom_range(500, 1));
            if (pwr > 32767) begin
                pwr = 32767;
            end
        end else begin
            pwr = int'($signed(16'($urandom)));
        end
        w.pack_millivolts = MV_W'(mv);
        w.power_watts     = PWR_W'(pwr);
        return w;
    endfunction

    task automatic run_phase(input int unsigned cells, input int unsigned ah,
                             input int unsigned limit, input int n);
        configure(cells, ah, limit);
        for (int i = 0; i < n; i++) begin
            sample_q = {sample_q, random_sample()};
        end
        settle();
    endtask

    function automatic t_in_word mk(input int unsigned mv, input int pwr);
        t_in_word w;
        w.pack_millivolts = MV_W'(mv);
        w.power_watts     = PWR_W'(pwr);
        return w;
    endfunction

    initial begin
        cfg_cells       = 0;
        cfg_amp_hours   = 0;
        cfg_power_limit = 300;
        win_count       = 0;
        win_head        = 0;
        win_sum         = 0;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            win_mv[i] = 0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: no cell count yet, so the sample is ignored
        sample_q = {sample_q, mk(4000, 0)};
        settle();

        // the spare index must not disturb anything
        cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
        configure(1, 1023, 300);
        sample_q = {sample_q, mk(0, 0)};              // no reading
        sample_q = {sample_q, mk(3270, 500)};         // empty window, high draw
        sample_q = {sample_q, mk(4200, 300)};         // empty window, draw at limit
        sample_q = {sample_q, mk(65535, -32768)};     // field extremes
        sample_q = {sample_q, mk(3271, 32767)};       // high draw, window not empty
        sample_q = {sample_q, mk(3270, 0)};
        sample_q = {sample_q, mk(3330, -1)};
        sample_q = {sample_q, mk(3390, 0)};
        sample_q = {sample_q, mk(3500, 100)};
        sample_q = {sample_q, mk(4199, 299)};
        sample_q = {sample_q, mk(4100, 1)};           // window now full
        sample_q = {sample_q, mk(3740, 0)};
        sample_q = {sample_q, mk(4130, -300)};
        sample_q = {sample_q, mk(3000, 0)};
        sample_q = {sample_q, mk(65535, 0)};
        settle();

        // random part over a range of register settings
        run_phase(1, 1023, 32767, 60);
        run_phase(31, 0, 0, 45);
        calm = 1'b1;
        run_phase(4, 250, 300, 60);
        calm = 1'b0;
        run_phase(12, $urandom_range(1023), $urandom_range(32767), 60);
        run_phase(0, 7, 300, 20);
        run_phase(15, 1023, $urandom_range(2000), 60);
        run_phase(8, $urandom_range(1023, 1), 1000, 60);

        // drain plus the block's worst-case update time
        settle();
        repeat (150) @(posedge i_clk);
        if (soc_expect_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, soc_expect_q.size());
            error_cnt++;
        end

        $display("run covered %0d samples and %0d checked results over %0d settings",
                 sent_cnt, checked_cnt, setting_cnt);
        $display("  %0d window-average updates, %0d first-sample estimates, %0d errors",
                 window_upd_cnt, first_soc_cnt, error_cnt);
        if (error_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
